// ----- rtl/assert_macros.svh -----
// assert_macros.svh: shared concurrent assertion macros.
// All macros sample on i_clk; the first two are disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, also checked through reset.
`define ASSERT_NXT_ALL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lag_pkg.sv -----
// ----------------------------------------------------------------------------
// lag_pkg
// Shared types and constants of the life grid engine.
// ----------------------------------------------------------------------------
package lag_pkg;

    localparam int DEF_GRID_WIDTH  = 64;
    localparam int DEF_GRID_HEIGHT = 64;

    localparam int CMD_W       = 2;
    localparam int COORD_W     = 6;
    localparam int COUNT_W     = 13;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // neighbor count and B3/S23 thresholds
    localparam int NBR_W = 4;
    localparam logic [NBR_W-1:0] NBR_SURVIVE = 4'd2;
    localparam logic [NBR_W-1:0] NBR_BIRTH   = 4'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_TOGGLE = 2'd0,
        CMD_STEP   = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd;

    // control from the sequencer to the change counter
    typedef struct packed {
        logic clear;
        logic valid;
    } t_cnt_ctl;

endpackage

// ----- rtl/lag_row_evolve.sv -----
// ----------------------------------------------------------------------------
// lag_row_evolve
// Next generation of one row from the rows above, at and below it.
// ----------------------------------------------------------------------------
module lag_row_evolve #(
    parameter int GRID_WIDTH = lag_pkg::DEF_GRID_WIDTH
) (
    input  logic [GRID_WIDTH-1:0] i_above,
    input  logic [GRID_WIDTH-1:0] i_cur,
    input  logic [GRID_WIDTH-1:0] i_below,
    output logic [GRID_WIDTH-1:0] o_fresh
);
    import lag_pkg::*;

    logic [GRID_WIDTH+1:0] pa, pc, pb;   // dead cell padded on both sides
    logic [NBR_W-1:0]      nbr [GRID_WIDTH];

    assign pa = {1'b0, i_above, 1'b0};
    assign pc = {1'b0, i_cur, 1'b0};
    assign pb = {1'b0, i_below, 1'b0};

    always_comb begin
        for (int c = 0; c < GRID_WIDTH; c++) begin
            nbr[c] = NBR_W'(pa[c]) + NBR_W'(pa[c+1]) + NBR_W'(pa[c+2])
                   + NBR_W'(pb[c]) + NBR_W'(pb[c+1]) + NBR_W'(pb[c+2])
                   + NBR_W'(pc[c]) + NBR_W'(pc[c+2]);
            if (pc[c+1]) begin
                o_fresh[c] = (nbr[c] == NBR_SURVIVE) || (nbr[c] == NBR_BIRTH);
            end else begin
                o_fresh[c] = (nbr[c] == NBR_BIRTH);
            end
        end
    end

endmodule

// ----- rtl/lag_change_count.sv -----
// ----------------------------------------------------------------------------
// lag_change_count
// Pipelined popcount of changed cells per row, saturating accumulation.
// ----------------------------------------------------------------------------
module lag_change_count #(
    parameter int GRID_WIDTH = lag_pkg::DEF_GRID_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lag_pkg::t_cnt_ctl          i_ctl,
    input  logic [GRID_WIDTH-1:0]      i_diff,
    output logic                       o_busy,
    output logic [lag_pkg::COUNT_W-1:0] o_total
);
    import lag_pkg::*;

    localparam int NUM_LANES = (GRID_WIDTH + 7) / 8;
    localparam int PAD_W     = NUM_LANES * 8;
    localparam int LANE_W    = 4;
    localparam int SUM_W     = $clog2(PAD_W + 1);

    logic [PAD_W-1:0]   r_diff;
    logic               r_v1, r_v2;
    logic [LANE_W-1:0]  r_lane   [NUM_LANES];
    logic [LANE_W-1:0]  n_lane   [NUM_LANES];
    logic [SUM_W-1:0]   lane_sum;
    logic [COUNT_W:0]   acc_ext;
    logic [COUNT_W-1:0] n_total;
    logic [COUNT_W-1:0] r_total;

    // stage 2: per-byte counts
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            n_lane[l] = '0;
            for (int b = 0; b < 8; b++) begin
                n_lane[l] = n_lane[l] + LANE_W'(r_diff[l*8+b]);
            end
        end
    end

    // stage 3: lane sum and saturating add
    always_comb begin
        lane_sum = '0;
        for (int l = 0; l < NUM_LANES; l++) begin
            lane_sum = lane_sum + SUM_W'(r_lane[l]);
        end
        acc_ext = {1'b0, r_total} + (COUNT_W+1)'(lane_sum);
        n_total = (acc_ext > {1'b0, COUNT_MAX}) ? COUNT_MAX : acc_ext[COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_total <= '0;
        end else begin
            r_v1 <= i_ctl.valid;
            r_v2 <= r_v1;
            if (i_ctl.clear) begin
                r_total <= '0;
            end else if (r_v2) begin
                r_total <= n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_diff <= PAD_W'(i_diff);
        end
        if (r_v1) begin
            r_lane <= n_lane;
        end
    end

    assign o_busy  = r_v1 | r_v2;
    assign o_total = r_total;

endmodule

// ----- rtl/life_automaton_grid_engine.sv -----
// ----------------------------------------------------------------------------
// life_automaton_grid_engine
// B3/S23 cellular automaton on a fixed, non-wrapping grid held in one RAM.
// ----------------------------------------------------------------------------
//  channel | dir | tdata bits (low to high)
//  --------+-----+-----------------------------------------------------------
//  s       | in  | command[1:0], column[7:2], row[13:8], zero[15:14]
//  m       | out | cell_alive[0], changed_count[13:1], zero[15:14]
//
//  Toggle and read: one RAM read of the row; a toggle then writes the
//  modified row back. A step streams the grid through the RAM one row per cycle:
//  read/evolve/write, then a drain of the change counter, then the result.
//  One command at a time; s_tready is high only while idle.
//  After reset a clearing pass writes every row dead with s_tready low.
//  A stalled result waits in the output register.
// ----------------------------------------------------------------------------
module life_automaton_grid_engine #(
    parameter int GRID_WIDTH  = lag_pkg::DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = lag_pkg::DEF_GRID_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // command[1:0], column[7:2], row[13:8], zero pad [15:14]
    input  logic [lag_pkg::IN_TDATA_W-1:0] i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // cell_alive[0], changed_count[13:1], zero pad [15:14]
    output logic [lag_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import lag_pkg::*;

    localparam int ROW_W  = $clog2(GRID_HEIGHT);
    localparam int COL_W  = $clog2(GRID_WIDTH);
    localparam int IDX_W  = $clog2(GRID_HEIGHT + 2);
    localparam int REXT_W = ROW_W + COORD_W;
    localparam int PAD_W  = OUT_TDATA_W - COUNT_W - 1;

    typedef enum logic [2:0] {
        S_CLEAR,    // post-reset RAM clearing pass
        S_IDLE,
        S_CELL,     // row data back, toggle or read one cell
        S_STEP,     // row stream: read r, evolve r-2... write
        S_DRAIN,    // wait for change counter
        S_DONE      // hand result to output register
    } t_state;

    // input beat unpack
    t_cmd               in_cmd;
    logic [COORD_W-1:0] in_col, in_row;
    logic [REXT_W-1:0]  in_row_ext;
    logic [ROW_W-1:0]   in_row_addr;
    logic               in_inside;

    assign in_cmd      = t_cmd'(i_s_tdata[CMD_W-1:0]);
    assign in_col      = i_s_tdata[CMD_W +: COORD_W];
    assign in_row      = i_s_tdata[CMD_W+COORD_W +: COORD_W];
    assign in_row_ext  = {{ROW_W{1'b0}}, in_row};
    assign in_row_addr = in_row_ext[ROW_W-1:0];
    assign in_inside   = ({1'b0, in_col} < (COORD_W+1)'(GRID_WIDTH))
                      && (in_row_ext < REXT_W'(GRID_HEIGHT));

    // control and datapath registers
    t_state              r_state;
    logic [IDX_W-1:0]    r_idx;        // clear address / step sequence count
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic                r_inside;
    logic                r_is_toggle;
    logic [GRID_WIDTH-1:0] r_prev;     // unmodified row above the one evolved
    logic [GRID_WIDTH-1:0] r_cur;      // unmodified row being evolved
    logic                r_res_alive;
    logic [COUNT_W-1:0]  r_res_count;
    logic                r_out_valid;
    logic                r_out_alive;
    logic [COUNT_W-1:0]  r_out_count;
    logic                out_load;     // result moves into the output register

    // grid RAM, one row per entry, registered read
    logic [GRID_WIDTH-1:0] r_grid [GRID_HEIGHT];
    logic [GRID_WIDTH-1:0] r_rdata;
    logic                  mem_we;
    logic [ROW_W-1:0]      mem_waddr;
    logic [ROW_W-1:0]      mem_raddr;
    logic [GRID_WIDTH-1:0] mem_wdata;

    // step datapath
    logic [GRID_WIDTH-1:0] below;
    logic [GRID_WIDTH-1:0] fresh;
    logic [IDX_W-1:0]      idx_m2;
    logic                  step_wr;
    logic                  cell_bit;
    t_cnt_ctl              cnt_ctl;
    logic                  cnt_busy;
    logic [COUNT_W-1:0]    cnt_total;

    // The row arriving at sequence count i is row i-1; past the last row the
    // row below the bottom edge reads as dead.
    assign below    = (r_idx <= IDX_W'(GRID_HEIGHT)) ? r_rdata : '0;
    assign idx_m2   = r_idx - IDX_W'(2);
    assign step_wr  = (r_state == S_STEP) && (r_idx >= IDX_W'(2));
    assign cell_bit = r_rdata[r_col];

    assign cnt_ctl = '{
        clear: (r_state == S_IDLE) && i_s_tvalid && (in_cmd == CMD_STEP),
        valid: step_wr
    };

    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    lag_row_evolve #(
        .GRID_WIDTH (GRID_WIDTH)
    ) u_evolve (
        .i_above (r_prev),
        .i_cur   (r_cur),
        .i_below (below),
        .o_fresh (fresh)
    );

    lag_change_count #(
        .GRID_WIDTH (GRID_WIDTH)
    ) u_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cnt_ctl),
        .i_diff  (fresh ^ r_cur),
        .o_busy  (cnt_busy),
        .o_total (cnt_total)
    );

    // RAM port muxing. Writes of row r-2 never meet the read of row r, and
    // row r+1 is read before row r is rewritten, so no forwarding is needed.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_row;
        mem_wdata = r_rdata ^ ({{(GRID_WIDTH-1){1'b0}}, 1'b1} << r_col);
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[ROW_W-1:0];
                mem_wdata = '0;
            end
            S_STEP: begin
                mem_we    = step_wr;
                mem_waddr = idx_m2[ROW_W-1:0];
                mem_wdata = fresh;
            end
            S_CELL: begin
                mem_we = r_is_toggle && r_inside;
            end
            default: begin
            end
        endcase
    end

    assign mem_raddr = (r_state == S_STEP) ? r_idx[ROW_W-1:0] : in_row_addr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_grid[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_grid[mem_raddr];
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_inside    <= 1'b0;
            r_is_toggle <= 1'b0;
            r_prev      <= '0;
            r_cur       <= '0;
            r_res_alive <= 1'b0;
            r_res_count <= '0;
            r_out_valid <= 1'b0;
            r_out_alive <= 1'b0;
            r_out_count <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + IDX_W'(1);
                    if (r_idx == IDX_W'(GRID_HEIGHT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_col       <= in_col[COL_W-1:0];
                        r_row       <= in_row_addr;
                        r_inside    <= in_inside;
                        r_is_toggle <= (in_cmd == CMD_TOGGLE);
                        r_res_alive <= 1'b0;
                        r_res_count <= '0;
                        unique case (in_cmd)
                            CMD_TOGGLE, CMD_READ: begin
                                r_state <= S_CELL;
                            end
                            CMD_STEP: begin
                                r_state <= S_STEP;
                                r_idx   <= '0;
                                r_prev  <= '0;
                                r_cur   <= '0;
                            end
                            default: begin
                                // unused code: zero result, no state change
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_CELL: begin
                    r_res_alive <= r_inside & (cell_bit ^ r_is_toggle);
                    r_state     <= S_DONE;
                end
                S_STEP: begin
                    r_idx <= r_idx + IDX_W'(1);
                    if (r_idx != '0) begin
                        r_prev <= r_cur;
                        r_cur  <= below;
                    end
                    if (r_idx == IDX_W'(GRID_HEIGHT + 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!cnt_busy) begin
                        r_res_count <= cnt_total;
                        r_state     <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out_alive <= r_res_alive;
                        r_out_count <= r_res_count;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_out_count, r_out_alive};

endmodule

// ----- rtl/lag_checker.sv -----
// ----------------------------------------------------------------------------
// lag_checker
// Port-level checks of the life grid engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lag_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [lag_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import lag_pkg::*;

    // reset leaves both sides quiet (clearing pass follows)
    `ASSERT_NXT_ALL(a_reset_quiet, !i_rst_n, !o_s_tready && !o_m_tvalid, "busy after reset")

    // one command at a time: taking a beat makes the block busy
    `ASSERT_NXT(a_one_at_a_time, i_s_tvalid && o_s_tready, !o_s_tready, "ready right after accept")

    // a cell result never carries a change count
    `ASSERT_IMP(a_fields_excl, o_m_tvalid && o_m_tdata[0], o_m_tdata[COUNT_W:1] == '0,
        "alive cell with nonzero count")

    // a result beat only leaves by handshake
    `ASSERT_IMP(a_no_drop, $fell(o_m_tvalid) && $past(i_rst_n), $past(i_m_tready),
        "result dropped")

    // stalled result holds
    `ASSERT_NXT(a_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata),
        "stalled result changed")

endmodule

bind life_automaton_grid_engine lag_checker u_lag_checker (.*);
